// ----- design/npp_pkg.sv -----
package npp_pkg;

  // Default store depth, handed to the top level as its parameter default.
  localparam int POINTS_DEF = 64;

  localparam int COORD_W   = 16;
  localparam int THR_W     = 15;
  localparam int IDX_OUT_W = 6;

  // Squared magnitudes of 16-bit differences, and their sum with one carry bit.
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int LIMIT_W = 2 * THR_W;

  localparam int THR_RESET_VAL = 480;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(THR_RESET_VAL * THR_RESET_VAL);

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      frame_start;
  } npp_in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] earlier_index;
    logic [IDX_OUT_W-1:0] newer_index;
    logic                 last_of_run;
  } npp_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npp_state_t;

endpackage

// ----- design/near_point_pair_finder.sv -----
// Near point pair finder.
// Points of one 2D cloud arrive as input transactions on in_data; a transaction
// is taken at a rising edge where start is high and busy is low. Each point is
// stored at the next index of the cloud (frame_start restarts the cloud at
// index 0) and compared with every earlier point of the same cloud. For every
// earlier point closer than near_threshold, one result transaction names the
// pair on out_data, marked by out_strobe for exactly one cycle; last_of_run
// flags the final pair caused by the point. Results come with earlier_index
// ascending. A point that arrives while the store is full is dropped.
// A point with index n > 0 keeps busy high for one read of the point store
// per earlier point, plus the read, difference, square and compare pipeline;
// a point with index 0 or a dropped point leaves busy low. The memory read
// port gives one stored point per cycle.
// The receiver cannot stall: results are simply presented for one cycle.
// cfg_we writes near_threshold; the user must write it only while busy is low, as the block does not enforce this.
// Reset (rst_n low, synchronous) empties the cloud and sets the threshold to
// 480; stored coordinates are not cleared, as they are only read once written.
module near_point_pair_finder #(
  parameter int POINTS = npp_pkg::POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  npp_pkg::npp_in_t           in_data,
  input  logic                       cfg_we,
  input  logic [npp_pkg::THR_W-1:0]  cfg_wdata,
  output logic                       out_strobe,
  output npp_pkg::npp_out_t          out_data
);

  import npp_pkg::*;

  localparam int IDX_W = $clog2(POINTS);
  localparam int CNT_W = $clog2(POINTS + 1);
  localparam int RAM_W = 2 * COORD_W;

  // Control state.
  npp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] last_k_r, last_k_nxt;
  logic [LIMIT_W-1:0] limit_r;

  // The newly arrived point under comparison.
  logic signed [COORD_W-1:0] nx_r, ny_r;
  logic [IDX_W-1:0]          nidx_r;

  // Compare pipeline: RAM read, absolute difference, squares.
  logic               rd_v_r;
  logic [IDX_W-1:0]   rd_k_r;
  logic               v2_r;
  logic [IDX_W-1:0]   k2_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic               v3_r;
  logic [IDX_W-1:0]   k3_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;

  // One near pair is held back until it is known whether another follows.
  logic             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_k_r, pend_k_nxt;

  logic     out_strobe_r, out_strobe_nxt;
  npp_out_t out_data_r, out_data_nxt;

  logic                ram_we;
  logic                rd_en;
  logic                load;
  logic [CNT_W-1:0]    cnt_eff;
  logic [RAM_W-1:0]    rd_data;
  logic signed [COORD_W-1:0] sx, sy;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]    dx_abs, dy_abs;
  logic [SUM_W-1:0]    dist_sq;
  logic                near;
  logic                flush;

  // Both coordinates of a point share one memory word, x in the upper half.
  npp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_eff[IDX_W-1:0]),
    .wdata ({in_data.pos_x, in_data.pos_y}),
    .re    (rd_en),
    .raddr (k_r),
    .rdata (rd_data)
  );

  assign cnt_eff = in_data.frame_start ? '0 : count_r;

  // Difference magnitudes fit 16 bits unsigned, since |a - b| is at most 65535.
  assign sx     = rd_data[RAM_W-1:COORD_W];
  assign sy     = rd_data[COORD_W-1:0];
  assign dx     = {nx_r[COORD_W-1], nx_r} - {sx[COORD_W-1], sx};
  assign dy     = {ny_r[COORD_W-1], ny_r} - {sy[COORD_W-1], sy};
  assign dx_abs = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
  assign dy_abs = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);

  // Squares are compared directly against the squared threshold.
  assign dist_sq = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign near    = v3_r && (dist_sq < SUM_W'(limit_r));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    last_k_nxt     = last_k_r;
    ram_we         = 1'b0;
    rd_en          = 1'b0;
    load           = 1'b0;
    flush          = 1'b0;
    pend_v_nxt     = pend_v_r;
    pend_k_nxt     = pend_k_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // A full store drops the point; frame_start always makes room.
          if (cnt_eff < CNT_W'(POINTS)) begin
            ram_we    = 1'b1;
            load      = 1'b1;
            count_nxt = cnt_eff + 1'b1;
            if (cnt_eff != '0) begin
              state_nxt  = ST_SCAN;
              k_nxt      = '0;
              last_k_nxt = IDX_W'(cnt_eff - 1'b1);
            end
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        k_nxt = IDX_W'(k_r + 1'b1);
        if (k_r == last_k_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !v2_r && !v3_r) begin
          state_nxt = ST_IDLE;
          flush     = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new near pair releases the held one as not last; the end of the scan
    // releases it as the last of the run.
    if (near) begin
      if (pend_v_r) begin
        out_strobe_nxt             = 1'b1;
        out_data_nxt.earlier_index = IDX_OUT_W'(pend_k_r);
        out_data_nxt.newer_index   = IDX_OUT_W'(nidx_r);
        out_data_nxt.last_of_run   = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_k_nxt = k3_r;
    end else if (flush && pend_v_r) begin
      out_strobe_nxt             = 1'b1;
      out_data_nxt.earlier_index = IDX_OUT_W'(pend_k_r);
      out_data_nxt.newer_index   = IDX_OUT_W'(nidx_r);
      out_data_nxt.last_of_run   = 1'b1;
      pend_v_nxt                 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      k_r          <= '0;
      last_k_r     <= '0;
      limit_r      <= LIMIT_RESET;
      rd_v_r       <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      k_r          <= k_nxt;
      last_k_r     <= last_k_nxt;
      rd_v_r       <= rd_en;
      v2_r         <= rd_v_r;
      v3_r         <= v2_r;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        limit_r <= LIMIT_W'(cfg_wdata) * LIMIT_W'(cfg_wdata);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      nx_r   <= in_data.pos_x;
      ny_r   <= in_data.pos_y;
      nidx_r <= cnt_eff[IDX_W-1:0];
    end
    rd_k_r     <= k_r;
    k2_r       <= rd_k_r;
    dx_r       <= dx_abs[COORD_W-1:0];
    dy_r       <= dy_abs[COORD_W-1:0];
    k3_r       <= k2_r;
    sqx_r      <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r      <= SQ_W'(dy_r) * SQ_W'(dy_r);
    pend_k_r   <= pend_k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- design/npp_ram.sv -----
module npp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual-port array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/npp_checker.sv -----
module npp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_strobe,
  input npp_pkg::npp_out_t         out_data
);

  import npp_pkg::*;

  // Results are only produced while a point is being compared.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // The earlier point of a pair always has the lower index.
  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.earlier_index < out_data.newer_index))
    else $error("earlier_index not below newer_index");

  // Back-to-back results inside one run name the same newer point.
  a_run_same_newer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe) && !$past(out_data.last_of_run)) |->
    (out_data.newer_index == $past(out_data.newer_index)))
    else $error("newer_index changed within a run");

  // A freshly taken point cannot produce a result on the next cycle.
  a_quiet_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("result strobe directly after an accepted transaction");

endmodule

bind near_point_pair_finder npp_checker u_npp_checker (.*);
